// ----- hdl/lmfe_pkg.sv -----
// Shared types and codes for the LIN master frame engine.
`default_nettype none
package lmfe_pkg;

  // Largest payload a frame may carry; longer requests are clamped.
  localparam logic [3:0] MAX_PAYLOAD = 4'd8;

  localparam logic [23:0] TIMEOUT_RESET = 24'd17360;
  localparam logic [7:0]  SYNC_BYTE     = 8'h55;
  localparam logic [5:0]  DIAG_ID_REQ   = 6'h3C;
  localparam logic [5:0]  DIAG_ID_RSP   = 6'h3D;
  localparam logic [7:0]  TICK_US       = 8'd100;

  // Request operation codes.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_SEND  = 2'd1;
  localparam logic [1:0] OP_RECV  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_BREAK = 2'd0;
  localparam logic [1:0] KIND_TX    = 2'd1;
  localparam logic [1:0] KIND_RX    = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  // Finish status codes.
  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_TIMEOUT  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WDATA = 3'd1,
    PH_WSYNC = 3'd2,
    PH_WID   = 3'd3,
    PH_RDATA = 3'd4,
    PH_RCK   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] frame_id;
    logic       enhanced;
    logic       is_read;
    logic [3:0] length;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic [3:0] rx_count;
    logic       last;
  } rsp_t;

endpackage
`default_nettype wire

// ----- hdl/lin_master_frame_engine_unit.sv -----
// LIN master frame engine: request register, frame logic and result queue.
//
//   channel | direction | handshake                | beat
//   --------+-----------+--------------------------+--------------------------
//   req     | in        | req_valid / req_ready    | one request (req_t)
//   rsp     | out       | rsp_valid / rsp_ready    | one result (rsp_t)
//   cfg     | in        | cfg_we, no wait          | timeout in microseconds
//
// A request beat lands in a request register. Once the result queue is free the
// frame logic evaluates it in one pass and loads all of its results (up to four)
// into a four-entry result queue that drains one beat per cycle while rsp_ready
// is high. A request producing a single result can therefore follow every cycle
// while rsp_ready is high; a request producing several results holds the request
// register until the result queue is down to its last beat and that beat is taken.
// Reset is synchronous: the frame returns to idle, the request register and
// the result queue empty, and the timeout returns to 17360 us. A stalled
// result holds its beat and backs up into the request register, which then
// drops req_ready.
`default_nettype none
module lin_master_frame_engine_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire lmfe_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output lmfe_pkg::rsp_t     rsp,
  input  wire logic          cfg_we,
  input  wire logic [23:0]   cfg_data
);
  import lmfe_pkg::*;

  // Protected ID: parity P0 in bit 6, inverted parity P1 in bit 7.
  function automatic logic [7:0] make_pid(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // Eight-bit add with the carry folded back in.
  function automatic logic [7:0] add_carry(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

  // Configuration.
  logic [23:0] timeout_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_us <= cfg_data;
    end
  end

  // Request register.
  req_t req_q;
  logic req_full;

  // Result queue: entry 0 is the head, entries shift down as beats leave.
  rsp_t       rq [4];
  logic [2:0] rq_count;
  logic       rq_free;
  logic       go;

  assign rsp_valid = (rq_count != 3'd0);
  assign rsp       = rq[0];
  assign rq_free   = (rq_count == 3'd0) || ((rq_count == 3'd1) && rsp_ready);
  assign go        = req_full && rq_free;
  assign req_ready = !req_full || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (req_valid && req_ready) begin
      req_full <= 1'b1;
    end else if (go) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  // Frame state.
  phase_t      phase, phase_next;
  logic [7:0]  protected_id, protected_id_next;
  logic [3:0]  frame_length, frame_length_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [7:0]  checksum_sum, checksum_sum_next;
  logic [23:0] elapsed_us, elapsed_us_next;

  rsp_t       res [4];
  logic [2:0] res_n;

  logic [3:0]  len_c;
  logic [7:0]  pid_c;
  logic [7:0]  sum_c;
  logic [3:0]  cnt_inc;
  logic [24:0] el_sum;
  logic [23:0] el_sat;

  always_comb begin
    phase_next        = phase;
    protected_id_next = protected_id;
    frame_length_next = frame_length;
    byte_count_next   = byte_count;
    checksum_sum_next = checksum_sum;
    elapsed_us_next   = elapsed_us;
    res_n             = 3'd0;
    for (int i = 0; i < 4; i++) begin
      res[i] = '0;
    end

    len_c   = (req_q.length > MAX_PAYLOAD) ? MAX_PAYLOAD : req_q.length;
    pid_c   = make_pid(req_q.frame_id);
    sum_c   = add_carry(checksum_sum, req_q.data_byte);
    cnt_inc = byte_count + 4'd1;
    el_sum  = {1'b0, elapsed_us} + {17'd0, TICK_US};
    el_sat  = el_sum[24] ? '1 : el_sum[23:0];

    unique case (req_q.operation)
      OP_START: begin
        protected_id_next = pid_c;
        frame_length_next = len_c;
        byte_count_next   = 4'd0;
        elapsed_us_next   = 24'd0;
        // Diagnostic frames always use the classic checksum.
        checksum_sum_next = (req_q.enhanced && req_q.frame_id != DIAG_ID_REQ
                             && req_q.frame_id != DIAG_ID_RSP) ? pid_c : 8'd0;
        res[0].kind     = KIND_BREAK;
        res[1].kind     = KIND_TX;
        res[1].out_byte = SYNC_BYTE;
        res[2].kind     = KIND_TX;
        res[2].out_byte = pid_c;
        res_n           = 3'd3;
        if (req_q.is_read) begin
          phase_next = PH_WSYNC;
        end else if (len_c == 4'd0) begin
          res[3].kind     = KIND_TX;
          res[3].out_byte = ~checksum_sum_next;
          res_n           = 3'd4;
          phase_next      = PH_IDLE;
        end else begin
          phase_next = PH_WDATA;
        end
      end
      OP_SEND: begin
        if (phase == PH_WDATA) begin
          checksum_sum_next = sum_c;
          byte_count_next   = cnt_inc;
          res[0].kind       = KIND_TX;
          res[0].out_byte   = req_q.data_byte;
          res_n             = 3'd1;
          if (cnt_inc >= frame_length) begin
            res[1].kind     = KIND_TX;
            res[1].out_byte = ~sum_c;
            res_n           = 3'd2;
            phase_next      = PH_IDLE;
          end
        end
      end
      OP_RECV: begin
        case (phase)
          PH_WSYNC: begin
            if (req_q.data_byte == SYNC_BYTE) begin
              phase_next = PH_WID;
            end
          end
          PH_WID: begin
            if (req_q.data_byte == protected_id) begin
              phase_next = (frame_length == 4'd0) ? PH_RCK : PH_RDATA;
            end
          end
          PH_RDATA: begin
            checksum_sum_next = sum_c;
            byte_count_next   = cnt_inc;
            res[0].kind       = KIND_RX;
            res[0].out_byte   = req_q.data_byte;
            res_n             = 3'd1;
            if (cnt_inc >= frame_length) begin
              phase_next = PH_RCK;
            end
          end
          PH_RCK: begin
            byte_count_next = cnt_inc;
            res[0].kind     = KIND_DONE;
            res[0].status   = (~checksum_sum == req_q.data_byte) ? ST_GOOD : ST_MISMATCH;
            res[0].rx_count = cnt_inc;
            res_n           = 3'd1;
            phase_next      = PH_IDLE;
          end
          default: begin
          end
        endcase
      end
      OP_TICK: begin
        if (phase inside {PH_WSYNC, PH_WID, PH_RDATA, PH_RCK}) begin
          elapsed_us_next = el_sat;
          if (el_sat >= timeout_us) begin
            res[0].kind     = KIND_DONE;
            res[0].status   = ST_TIMEOUT;
            res[0].rx_count = byte_count;
            res_n           = 3'd1;
            phase_next      = PH_IDLE;
          end
        end
      end
    endcase

    // Mark the final result of this request.
    for (int i = 0; i < 4; i++) begin
      res[i].last = (3'(i + 1) == res_n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      protected_id <= 8'd0;
      frame_length <= 4'd0;
      byte_count   <= 4'd0;
      checksum_sum <= 8'd0;
      elapsed_us   <= 24'd0;
    end else if (go) begin
      phase        <= phase_next;
      protected_id <= protected_id_next;
      frame_length <= frame_length_next;
      byte_count   <= byte_count_next;
      checksum_sum <= checksum_sum_next;
      elapsed_us   <= elapsed_us_next;
    end
  end

  // Queue occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      rq_count <= 3'd0;
    end else if (go) begin
      rq_count <= res_n;
    end else if (rsp_valid && rsp_ready) begin
      rq_count <= rq_count - 3'd1;
    end
  end

  // Queue entries: a load replaces the whole queue, which is then empty or
  // losing its last beat; otherwise a taken beat shifts the rest down.
  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < 4; i++) begin
        rq[i] <= res[i];
      end
    end else if (rsp_valid && rsp_ready) begin
      for (int i = 0; i < 3; i++) begin
        rq[i] <= rq[i + 1];
      end
      rq[3] <= '0;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lmfe_checker.sv -----
// Port-level checks for the LIN master frame engine, bound to the top level.
`default_nettype none
module lmfe_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire lmfe_pkg::rsp_t rsp
);
  import lmfe_pkg::*;

  // A break result is never the last result of its request.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.kind == KIND_BREAK) |-> !rsp.last)
    else $error("break request marked as last result");

  // A finished frame is always the final result of its request.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.kind == KIND_DONE) |-> rsp.last)
    else $error("frame finish not marked as last result");

  // Status and count only appear on a finish.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.kind != KIND_DONE) |-> (rsp.status == ST_GOOD && rsp.rx_count == 4'd0))
    else $error("status or count set outside a frame finish");

  // A stalled result beat holds.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("result beat changed while stalled");

endmodule

bind lin_master_frame_engine_unit lmfe_checker u_lmfe_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
`default_nettype wire

// ----- bench/lmfe_frame_checker.sv -----
// Checker for the LIN master frame engine: predicts every result beat and compares it.
`timescale 1ns / 1ps
module lmfe_frame_checker (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  input  wire logic           req_ready,
  input  wire lmfe_pkg::req_t req,
  input  wire logic           rsp_valid,
  input  wire logic           rsp_ready,
  input  wire lmfe_pkg::rsp_t rsp,
  input  wire logic           cfg_we,
  input  wire logic [23:0]    cfg_data,
  output int                  mismatches,
  output int                  outstanding
);
  import lmfe_pkg::*;

  rsp_t        expected_beats[$];
  phase_t      phase;
  logic [7:0]  pid;
  logic [3:0]  frame_len;
  logic [3:0]  byte_cnt;
  logic [7:0]  sum;
  logic [24:0] elapsed;
  logic [23:0] timeout;
  int          reported;

  function automatic logic [7:0] protected_id_of(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // Eight-bit sum where the carry out is added back into bit zero.
  function automatic logic [7:0] add_end_carry(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

  function automatic string beat_text(input rsp_t b);
    return $sformatf("kind %0d byte %02h status %0d count %0d last %0b",
                     b.kind, b.out_byte, b.status, b.rx_count, b.last);
  endfunction

  task automatic queue_beat(input logic [1:0] kind, input logic [7:0] value,
                            input logic [1:0] status, input logic [3:0] count);
    rsp_t e;
    e.kind     = kind;
    e.out_byte = value;
    e.status   = status;
    e.rx_count = count;
    e.last     = 1'b0;
    expected_beats.push_back(e);
  endtask

  task automatic predict_frame_beats(input req_t r);
    int         queued;
    logic [3:0] len;
    rsp_t       tail;
    queued = expected_beats.size();
    case (r.operation)
      OP_START: begin
        len       = (r.length > MAX_PAYLOAD) ? MAX_PAYLOAD : r.length;
        pid       = protected_id_of(r.frame_id);
        frame_len = len;
        byte_cnt  = 4'd0;
        elapsed   = '0;
        // Diagnostic frames always fall back to the classic checksum.
        sum = (r.enhanced && r.frame_id != DIAG_ID_REQ && r.frame_id != DIAG_ID_RSP) ?
              pid : 8'h00;
        queue_beat(KIND_BREAK, 8'h00, ST_GOOD, 4'd0);
        queue_beat(KIND_TX, SYNC_BYTE, ST_GOOD, 4'd0);
        queue_beat(KIND_TX, pid, ST_GOOD, 4'd0);
        if (r.is_read) begin
          phase = PH_WSYNC;
        end else if (len == 4'd0) begin
          queue_beat(KIND_TX, ~sum, ST_GOOD, 4'd0);
          phase = PH_IDLE;
        end else begin
          phase = PH_WDATA;
        end
      end
      OP_SEND: begin
        if (phase == PH_WDATA) begin
          sum      = add_end_carry(sum, r.data_byte);
          byte_cnt = byte_cnt + 4'd1;
          queue_beat(KIND_TX, r.data_byte, ST_GOOD, 4'd0);
          if (byte_cnt >= frame_len) begin
            queue_beat(KIND_TX, ~sum, ST_GOOD, 4'd0);
            phase = PH_IDLE;
          end
        end
      end
      OP_RECV: begin
        case (phase)
          PH_WSYNC: begin
            if (r.data_byte == SYNC_BYTE) phase = PH_WID;
          end
          PH_WID: begin
            if (r.data_byte == pid) phase = (frame_len == 4'd0) ? PH_RCK : PH_RDATA;
          end
          PH_RDATA: begin
            sum      = add_end_carry(sum, r.data_byte);
            byte_cnt = byte_cnt + 4'd1;
            queue_beat(KIND_RX, r.data_byte, ST_GOOD, 4'd0);
            if (byte_cnt >= frame_len) phase = PH_RCK;
          end
          PH_RCK: begin
            byte_cnt = byte_cnt + 4'd1;
            queue_beat(KIND_DONE, 8'h00, (~sum == r.data_byte) ? ST_GOOD : ST_MISMATCH,
                       byte_cnt);
            phase = PH_IDLE;
          end
          default: begin
          end
        endcase
      end
      default: begin
        if (phase >= PH_WSYNC && phase <= PH_RCK) begin
          elapsed = elapsed + TICK_US;
          if (elapsed > 25'hFF_FFFF) elapsed = 25'hFF_FFFF;
          if (elapsed >= {1'b0, timeout}) begin
            queue_beat(KIND_DONE, 8'h00, ST_TIMEOUT, byte_cnt);
            phase = PH_IDLE;
          end
        end
      end
    endcase
    if (expected_beats.size() > queued) begin
      tail      = expected_beats.pop_back();
      tail.last = 1'b1;
      expected_beats.push_back(tail);
    end
  endtask

  task automatic compare_beat(input rsp_t got);
    rsp_t want;
    if (expected_beats.size() == 0) begin
      mismatches++;
      if (reported < 10)
        $display("%0t: result beat with none expected: %s", $realtime, beat_text(got));
      reported++;
    end else begin
      want = expected_beats.pop_front();
      if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
          got.status !== want.status || got.rx_count !== want.rx_count ||
          got.last !== want.last) begin
        mismatches++;
        if (reported < 10)
          $display("%0t: expected %s, got %s", $realtime, beat_text(want),
                   beat_text(got));
        reported++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase      = PH_IDLE;
      pid        = 8'h00;
      frame_len  = 4'd0;
      byte_cnt   = 4'd0;
      sum        = 8'h00;
      elapsed    = '0;
      timeout    = TIMEOUT_RESET;
      mismatches = 0;
      reported   = 0;
      expected_beats.delete();
    end else begin
      // A result leaving now always belongs to an earlier request, so pop first.
      if (rsp_valid && rsp_ready) compare_beat(rsp);
      if (cfg_we) timeout = cfg_data;
      if (req_valid && req_ready) predict_frame_beats(req);
    end
    outstanding = expected_beats.size();
  end

endmodule

// ----- bench/tb_lin_master_frame_engine_unit.sv -----
// Top of the LIN master frame engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_lin_master_frame_engine_unit;
  import lmfe_pkg::*;

  // Extra cycles allowed after the last expected beat, covering the request
  // register, the evaluation cycle and the four-entry result queue.
  localparam int DRAIN_CYCLES    = 8;
  localparam int BEATS_PER_PHASE = 50;
  // Ticks given to a read frame at the largest timeout; none of them ends it.
  localparam int QUIET_TICKS     = 8;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_t        rsp;
  logic        cfg_we;
  logic [23:0] cfg_data;
  int          mismatches;
  int          outstanding;

  // When set, the matching side of the handshake runs without idle cycles.
  bit sender_steady;
  bit sink_steady;
  int beats_sent;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lin_master_frame_engine_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  lmfe_frame_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // The slave side of the line needs the protected ID and a running checksum
  // to echo well-formed read frames back into the engine.
  function automatic logic [7:0] line_pid(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  function automatic logic [7:0] carry_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

  function automatic logic [7:0] rnd8();
    logic [31:0] w;
    w = $urandom;
    return w[7:0];
  endfunction

  // A request beat with every field random except the operation, so that the
  // fields an operation ignores still see both values on every bit.
  function automatic req_t filler(input logic [1:0] op);
    logic [31:0] w;
    req_t        r;
    w           = $urandom;
    r           = w[$bits(req_t)-1:0];
    r.operation = op;
    return r;
  endfunction

  // Sender: wait a random number of idle cycles, then present the beat at the
  // falling edge and hold it until a rising edge sees req_ready. When the next
  // beat follows with no gap, valid simply stays high while the payload changes.
  task automatic drive_beat(input req_t r);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    beats_sent++;
  endtask

  task automatic start_frame(input logic [5:0] id, input logic enh, input logic rd,
                             input logic [3:0] len);
    req_t r;
    r          = filler(OP_START);
    r.frame_id = id;
    r.enhanced = enh;
    r.is_read  = rd;
    r.length   = len;
    drive_beat(r);
  endtask

  task automatic send_byte(input logic [7:0] value);
    req_t r;
    r           = filler(OP_SEND);
    r.data_byte = value;
    drive_beat(r);
  endtask

  task automatic line_byte(input logic [7:0] value);
    req_t r;
    r           = filler(OP_RECV);
    r.data_byte = value;
    drive_beat(r);
  endtask

  task automatic tick();
    drive_beat(filler(OP_TICK));
  endtask

  // Hold off the sender until every predicted beat has drained, then give the
  // engine a few more cycles in case the last request caused no result.
  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // The timeout register is only rewritten while the engine is idle.
  task automatic write_timeout(input logic [23:0] value);
    settle();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Ticks sprinkled into read frames; with a short timeout they end the frame
  // early and the rest of the frame turns into stray bytes.
  task automatic maybe_tick();
    if ($urandom_range(0, 7) == 0) tick();
  endtask

  // One frame with random content. Most frames are well formed so that reads
  // get through the sync and ID echo; the rest are noise or cut short, and a
  // cut-short frame leaves the next start to land on a busy engine.
  task automatic random_frame();
    logic [31:0] w;
    logic [5:0]  id;
    logic        enh;
    logic        rd;
    logic [3:0]  len;
    logic [7:0]  pid;
    logic [7:0]  sum;
    logic [7:0]  value;
    int          n;
    w   = $urandom;
    id  = w[5:0];
    enh = w[8];
    rd  = w[9];
    case ($urandom_range(0, 9))
      0: id = DIAG_ID_REQ;
      1: id = DIAG_ID_RSP;
      2: id = 6'h00;
      3: id = 6'h3F;
      default: begin
      end
    endcase
    len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    n   = (len > MAX_PAYLOAD) ? MAX_PAYLOAD : len;
    pid = line_pid(id);
    sum = (enh && id != DIAG_ID_REQ && id != DIAG_ID_RSP) ? pid : 8'h00;

    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) drive_beat(filler(2'($urandom_range(0, 3))));
      return;
    end

    start_frame(id, enh, rd, len);
    if (!rd) begin
      for (int k = 0; k < n; k++) begin
        // Ticks and line bytes are ignored while a write frame is sending.
        if ($urandom_range(0, 9) == 0)
          drive_beat(filler(($urandom_range(0, 1) == 0) ? OP_TICK : OP_RECV));
        if ($urandom_range(0, 40) == 0) return;
        value = rnd8();
        sum   = carry_add(sum, value);
        send_byte(value);
      end
    end else begin
      repeat ($urandom_range(0, 2)) begin
        line_byte(rnd8());
        maybe_tick();
      end
      if ($urandom_range(0, 30) == 0) return;
      line_byte(SYNC_BYTE);
      repeat ($urandom_range(0, 2)) begin
        line_byte(rnd8());
        maybe_tick();
      end
      if ($urandom_range(0, 30) == 0) return;
      line_byte(pid);
      for (int k = 0; k < n; k++) begin
        maybe_tick();
        if ($urandom_range(0, 40) == 0) return;
        value = rnd8();
        sum   = carry_add(sum, value);
        line_byte(value);
      end
      maybe_tick();
      line_byte(($urandom_range(0, 3) == 0) ? rnd8() : ~sum);
    end
  endtask

  // One timeout setting followed by a stretch of random frames. Now and then
  // the sender waits for the engine to drain completely before going on.
  task automatic random_phase(input logic [23:0] limit_us);
    int stop_at;
    write_timeout(limit_us);
    stop_at = beats_sent + BEATS_PER_PHASE;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 24) == 0) settle();
      if ($urandom_range(0, 7) == 0) sender_steady = !sender_steady;
      random_frame();
    end
  endtask

  // Receiver: for every result beat draw a stall, then hold rsp_ready high until
  // a beat is taken. Every so often it switches between drawn stalls and a stretch with no stalls.
  initial begin
    int stall;
    rsp_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) sink_steady = !sink_steady;
      stall = sink_steady ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        @(negedge clk);
        rsp_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [7:0]  pid;
    logic [31:0] w;
    logic [7:0]  pattern [8];
    int          guard;
    pattern       = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
    rst           = 1'b1;
    req_valid     = 1'b0;
    req           = '0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    sender_steady = 1'b0;
    sink_steady   = 1'b0;
    beats_sent    = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Empty classic write frame: the checksum 0xFF follows the ID at once.
    start_frame(6'h00, 1'b0, 1'b0, 4'd0);
    // Ticks and line bytes with no frame running are ignored.
    tick();
    line_byte(rnd8());
    // An oversized length is clamped to eight payload bytes.
    start_frame(6'h3F, 1'b1, 1'b0, 4'd15);
    foreach (pattern[k]) send_byte(pattern[k]);
    // A payload byte after the frame has closed is ignored.
    send_byte(8'hFF);

    // Diagnostic read frame: enhanced is requested but classic must be used.
    // Bytes that are not the sync or the ID echo are thrown away on the way.
    pid = line_pid(DIAG_ID_REQ);
    start_frame(DIAG_ID_REQ, 1'b1, 1'b1, 4'd1);
    line_byte(8'h3C);
    line_byte(SYNC_BYTE);
    line_byte(~pid);
    line_byte(pid);
    line_byte(8'hC3);
    line_byte(~carry_add(8'h00, 8'hC3));

    // A start while a read frame is waiting drops that frame silently.
    start_frame(6'h07, 1'b1, 1'b1, 4'd3);
    line_byte(SYNC_BYTE);
    start_frame(DIAG_ID_RSP, 1'b1, 1'b0, 4'd0);

    // Zero timeout: the first tick of a read frame ends it.
    write_timeout(24'd0);
    start_frame(6'h15, 1'b0, 1'b1, 4'd2);
    tick();
    // Timeout partway through the payload reports the bytes seen so far.
    write_timeout(24'd300);
    pid = line_pid(6'h2A);
    start_frame(6'h2A, 1'b1, 1'b1, 4'd2);
    line_byte(SYNC_BYTE);
    line_byte(pid);
    line_byte(8'h5A);
    tick();
    tick();
    tick();

    // Random frames under several timeout settings, the extremes among them.
    random_phase(24'hFF_FFFF);
    random_phase(TIMEOUT_RESET);
    random_phase(24'd100);
    random_phase(24'd0);
    w = $urandom_range(200, 3000);
    random_phase(w[23:0]);
    w = $urandom;
    random_phase(w[23:0]);

    // At the largest timeout a short run of ticks leaves a read frame running.
    write_timeout(24'hFF_FFFF);
    sender_steady = 1'b1;
    w = $urandom;
    start_frame(w[5:0], w[6], 1'b1, 4'(w[11:8]));
    repeat (QUIET_TICKS) tick();
    sender_steady = 1'b0;

    // Wait for every predicted beat, bounded, then give the verdict.
    @(negedge clk);
    req_valid <= 1'b0;
    guard = 0;
    while (outstanding != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    if (outstanding != 0) begin
      $display("FAIL");
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (mismatches == 0 && outstanding == 0) begin
        $display("PASS");
      end else begin
        $display("FAIL");
      end
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
